>>> hdl/gdi_pkg.sv
// ----------------------------------------------------------------------------
// gdi_pkg
// Shared constants, types and helpers for the Gauss-Jordan determinant and
// inverse block.
// ----------------------------------------------------------------------------
package gdi_pkg;

    localparam int MATRIX_SIZE   = 5;
    localparam int FRACTION_BITS = 16;
    localparam int CELLS         = MATRIX_SIZE * MATRIX_SIZE;
    localparam int ADDR_W        = $clog2(CELLS);
    localparam int IDX_W         = 3;
    localparam int DATA_W        = 32;
    localparam int DIV_W         = DATA_W + FRACTION_BITS;
    localparam int CNT_W         = $clog2(DIV_W);

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MATRIX_SIZE - 1);
    localparam logic [IDX_W-1:0]  IDX_ONE   = IDX_W'(1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [DATA_W-1:0] ONE       = DATA_W'(64'd1 << FRACTION_BITS);

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SUB
    } alu_op_t;

    typedef struct packed {
        logic              start;
        alu_op_t           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
        logic              sat;
    } alu_rsp_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        logic [ADDR_W+IDX_W-1:0] full;
        full = (ADDR_W+IDX_W)'(row) * (ADDR_W+IDX_W)'(MATRIX_SIZE)
             + (ADDR_W+IDX_W)'(col);
        return full[ADDR_W-1:0];
    endfunction

endpackage

>>> hdl/gdi_ram.sv
// ----------------------------------------------------------------------------
// gdi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 25
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

>>> hdl/gdi_alu.sv
// ----------------------------------------------------------------------------
// gdi_alu
// Shared fixed-point unit: rounded multiply, bit-serial divide and subtract,
// all saturating to the word width.
// ----------------------------------------------------------------------------
module gdi_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  gdi_pkg::alu_req_t req,
    output gdi_pkg::alu_rsp_t rsp
);

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIN
    } alu_state_t;

    alu_state_t                        state_reg;
    logic signed [63:0]                prod_reg;
    logic [gdi_pkg::DATA_W-1:0]        rem_reg;
    logic [gdi_pkg::DIV_W-1:0]         quo_reg;
    logic [gdi_pkg::DATA_W-1:0]        den_reg;
    logic [gdi_pkg::CNT_W-1:0]         cnt_reg;
    logic                              neg_reg;
    logic                              done_reg;
    logic [gdi_pkg::DATA_W-1:0]        res_reg;
    logic                              sat_reg;

    logic signed [63:0]                rnd;
    logic signed [63:0]                wide;
    logic [gdi_pkg::DATA_W-1:0]        sat_value;
    logic                              sat_flag;
    logic                              finish;
    logic [gdi_pkg::DATA_W-1:0]        mag_a;
    logic [gdi_pkg::DATA_W-1:0]        mag_b;
    logic [gdi_pkg::DATA_W:0]          shifted;
    logic [gdi_pkg::DATA_W:0]          trial;

    assign rnd   = prod_reg + (64'sd1 <<< (gdi_pkg::FRACTION_BITS - 1));
    assign mag_a = req.a[gdi_pkg::DATA_W-1] ? (~req.a + 1'b1) : req.a;
    assign mag_b = req.b[gdi_pkg::DATA_W-1] ? (~req.b + 1'b1) : req.b;
    assign shifted = {rem_reg, quo_reg[gdi_pkg::DIV_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb begin
        wide   = 64'sd0;
        finish = 1'b0;
        case (state_reg)
            A_IDLE: begin
                wide   = {{32{req.a[31]}}, req.a} - {{32{req.b[31]}}, req.b};
                finish = req.start && (req.op == gdi_pkg::OP_SUB);
            end
            A_MUL: begin
                wide   = rnd >>> gdi_pkg::FRACTION_BITS;
                finish = 1'b1;
            end
            A_FIN: begin
                wide   = neg_reg ? -$signed(64'(quo_reg)) : $signed(64'(quo_reg));
                finish = 1'b1;
            end
            default: begin
                wide   = 64'sd0;
                finish = 1'b0;
            end
        endcase
    end

    always_comb begin
        sat_flag  = 1'b0;
        sat_value = wide[31:0];
        if (!wide[63] && (|wide[62:31])) begin
            sat_flag  = 1'b1;
            sat_value = 32'h7FFF_FFFF;
        end else if (wide[63] && !(&wide[62:31])) begin
            sat_flag  = 1'b1;
            sat_value = 32'h8000_0000;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= finish;
            if (finish) begin
                res_reg <= sat_value;
                sat_reg <= sat_flag;
            end
            case (state_reg)
                A_IDLE: begin
                    if (req.start && req.op == gdi_pkg::OP_MUL) begin
                        prod_reg  <= $signed(req.a) * $signed(req.b);
                        state_reg <= A_MUL;
                    end else if (req.start && req.op == gdi_pkg::OP_DIV) begin
                        neg_reg   <= req.a[gdi_pkg::DATA_W-1] ^ req.b[gdi_pkg::DATA_W-1];
                        quo_reg   <= {mag_a, {gdi_pkg::FRACTION_BITS{1'b0}}};
                        den_reg   <= mag_b;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= A_DIV;
                    end
                end
                A_MUL: begin
                    state_reg <= A_IDLE;
                end
                A_DIV: begin
                    if (!trial[gdi_pkg::DATA_W]) begin
                        rem_reg <= trial[gdi_pkg::DATA_W-1:0];
                        quo_reg <= {quo_reg[gdi_pkg::DIV_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= shifted[gdi_pkg::DATA_W-1:0];
                        quo_reg <= {quo_reg[gdi_pkg::DIV_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == gdi_pkg::CNT_W'(gdi_pkg::DIV_W - 1)) begin
                        state_reg <= A_FIN;
                    end
                end
                A_FIN: begin
                    state_reg <= A_IDLE;
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;
    assign rsp.sat    = sat_reg;

endmodule

>>> hdl/gauss_determinant_and_inverse_top.sv
// Input: N*N elements per matrix. Elimination runs every division bit-serially
// in the shared unit; each row element update is a multiply then a subtract, or
// a multiply alone when scaling. One matrix at a time; not ready while computing.
// Reset: synchronous, active low; clears the sequencer, load count and output
// valid. Matrix RAMs are not cleared.
// ----------------------------------------------------------------------------
// gauss_determinant_and_inverse_top
// Loads a matrix, eliminates with a shared arithmetic unit under a sequencer,
// and streams out the inverse with determinant and status flags.
// ----------------------------------------------------------------------------
module gauss_determinant_and_inverse_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_element,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_inverse_value,
    output logic [2:0]  m_row_index,
    output logic [2:0]  m_column_index,
    output logic [31:0] m_determinant,
    output logic        m_singular,
    output logic        m_overflow,
    output logic        m_last
);

    typedef enum logic [4:0] {
        S_LOAD,
        S_INIT,
        S_DN_PIV,
        S_DN_CHK,
        S_DN_RD,
        S_DN_DIV,
        S_DN_DIV_W,
        S_DET,
        S_DET_MUL,
        S_DET_W,
        S_SC_RD,
        S_SC_DIV,
        S_SC_DIV_W,
        S_BK_PIV,
        S_BK_CHK,
        S_BK_RD,
        S_BK_DIV,
        S_BK_DIV_W,
        S_RS_RD,
        S_RS_MUL,
        S_RS_MUL_W,
        S_RS_SUB,
        S_RS_SUB_W,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_W
    } state_t;

    typedef enum logic [1:0] {
        PH_DOWN,
        PH_SCALE,
        PH_BACK
    } phase_t;

    state_t                          state_reg;
    phase_t                          phase_reg;
    logic [gdi_pkg::ADDR_W-1:0]      load_cnt_reg;
    logic [gdi_pkg::IDX_W-1:0]       i_reg;
    logic [gdi_pkg::IDX_W-1:0]       r_reg;
    logic [gdi_pkg::IDX_W-1:0]       c_reg;
    logic                            m_sel_reg;
    logic [gdi_pkg::DATA_W-1:0]      pivot_reg;
    logic [gdi_pkg::DATA_W-1:0]      p_reg;
    logic [gdi_pkg::DATA_W-1:0]      t_reg;
    logic [gdi_pkg::DATA_W-1:0]      det_reg;
    logic                            ovf_reg;

    logic                            m_valid_reg;
    logic [gdi_pkg::DATA_W-1:0]      m_inverse_value_reg;
    logic [gdi_pkg::IDX_W-1:0]       m_row_index_reg;
    logic [gdi_pkg::IDX_W-1:0]       m_column_index_reg;
    logic [gdi_pkg::DATA_W-1:0]      m_determinant_reg;
    logic                            m_singular_reg;
    logic                            m_overflow_reg;
    logic                            m_last_reg;

    gdi_pkg::alu_req_t               alu_req;
    gdi_pkg::alu_rsp_t               alu_rsp;

    logic [gdi_pkg::ADDR_W-1:0]      rd_addr;
    logic [gdi_pkg::ADDR_W-1:0]      wr_addr;
    logic [gdi_pkg::DATA_W-1:0]      wr_data;
    logic                            work_we;
    logic                            inv_we;
    logic [gdi_pkg::DATA_W-1:0]      work_rd;
    logic [gdi_pkg::DATA_W-1:0]      inv_rd;
    logic [gdi_pkg::DATA_W-1:0]      sel_rd;
    logic                            row_write;
    logic                            s_accept;

    assign s_ready  = (state_reg == S_LOAD);
    assign s_accept = s_valid && s_ready;
    assign sel_rd   = m_sel_reg ? inv_rd : work_rd;

    assign row_write = alu_rsp.done
                    && ((state_reg == S_RS_SUB_W)
                    || (state_reg == S_RS_MUL_W && phase_reg == PH_SCALE));

    always_comb begin
        case (state_reg)
            S_DN_PIV, S_DET, S_SC_RD, S_BK_PIV: rd_addr = gdi_pkg::cell_addr(i_reg, i_reg);
            S_DN_RD, S_BK_RD:                   rd_addr = gdi_pkg::cell_addr(r_reg, i_reg);
            S_RS_RD:                            rd_addr = gdi_pkg::cell_addr(i_reg, c_reg);
            S_RS_MUL_W, S_OUT_RD:               rd_addr = gdi_pkg::cell_addr(r_reg, c_reg);
            default:                            rd_addr = '0;
        endcase
    end

    always_comb begin
        case (state_reg)
            S_LOAD: begin
                wr_addr = load_cnt_reg;
                wr_data = s_element;
            end
            S_INIT: begin
                wr_addr = gdi_pkg::cell_addr(i_reg, c_reg);
                wr_data = (i_reg == c_reg) ? gdi_pkg::ONE : '0;
            end
            default: begin
                wr_addr = gdi_pkg::cell_addr(r_reg, c_reg);
                wr_data = alu_rsp.result;
            end
        endcase
    end

    assign work_we = s_accept || (row_write && !m_sel_reg);
    assign inv_we  = (state_reg == S_INIT) || (row_write && m_sel_reg);

    always_comb begin
        alu_req.start = 1'b0;
        alu_req.op    = gdi_pkg::OP_MUL;
        alu_req.a     = sel_rd;
        alu_req.b     = p_reg;
        case (state_reg)
            S_DN_DIV, S_BK_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = gdi_pkg::OP_DIV;
                alu_req.a     = work_rd;
                alu_req.b     = pivot_reg;
            end
            S_SC_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = gdi_pkg::OP_DIV;
                alu_req.a     = gdi_pkg::ONE;
                alu_req.b     = work_rd;
            end
            S_DET_MUL: begin
                alu_req.start = 1'b1;
                alu_req.a     = det_reg;
                alu_req.b     = work_rd;
            end
            S_RS_MUL: begin
                alu_req.start = 1'b1;
            end
            S_RS_SUB: begin
                alu_req.start = 1'b1;
                alu_req.op    = gdi_pkg::OP_SUB;
                alu_req.b     = t_reg;
            end
            default: begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    gdi_ram #(
        .WIDTH (gdi_pkg::DATA_W),
        .DEPTH (gdi_pkg::CELLS)
    ) u_work_ram (
        .aclk    (aclk),
        .wr_en   (work_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (work_rd)
    );

    gdi_ram #(
        .WIDTH (gdi_pkg::DATA_W),
        .DEPTH (gdi_pkg::CELLS)
    ) u_inv_ram (
        .aclk    (aclk),
        .wr_en   (inv_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (inv_rd)
    );

    gdi_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    if (s_accept) begin
                        if (load_cnt_reg == gdi_pkg::LAST_CELL) begin
                            load_cnt_reg <= '0;
                            i_reg        <= '0;
                            c_reg        <= '0;
                            det_reg      <= '0;
                            ovf_reg      <= 1'b0;
                            state_reg    <= S_INIT;
                        end else begin
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                        end
                    end
                end
                S_INIT: begin
                    if (c_reg == gdi_pkg::LAST_IDX) begin
                        c_reg <= '0;
                        if (i_reg == gdi_pkg::LAST_IDX) begin
                            i_reg     <= '0;
                            state_reg <= S_DN_PIV;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end else begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                S_DN_PIV: begin
                    state_reg <= S_DN_CHK;
                end
                S_DN_CHK: begin
                    pivot_reg <= work_rd;
                    if (work_rd == '0) begin
                        m_valid_reg         <= 1'b1;
                        m_inverse_value_reg <= '0;
                        m_row_index_reg     <= '0;
                        m_column_index_reg  <= '0;
                        m_determinant_reg   <= det_reg;
                        m_singular_reg      <= 1'b1;
                        m_overflow_reg      <= ovf_reg;
                        m_last_reg          <= 1'b1;
                        state_reg           <= S_OUT_W;
                    end else if (i_reg == gdi_pkg::LAST_IDX) begin
                        i_reg     <= '0;
                        det_reg   <= gdi_pkg::ONE;
                        state_reg <= S_DET;
                    end else begin
                        r_reg     <= gdi_pkg::LAST_IDX;
                        state_reg <= S_DN_RD;
                    end
                end
                S_DN_RD: begin
                    state_reg <= S_DN_DIV;
                end
                S_DN_DIV: begin
                    state_reg <= S_DN_DIV_W;
                end
                S_DN_DIV_W: begin
                    if (alu_rsp.done) begin
                        p_reg     <= alu_rsp.result;
                        ovf_reg   <= ovf_reg | alu_rsp.sat;
                        c_reg     <= '0;
                        m_sel_reg <= 1'b0;
                        phase_reg <= PH_DOWN;
                        state_reg <= S_RS_RD;
                    end
                end
                S_DET: begin
                    state_reg <= S_DET_MUL;
                end
                S_DET_MUL: begin
                    state_reg <= S_DET_W;
                end
                S_DET_W: begin
                    if (alu_rsp.done) begin
                        det_reg <= alu_rsp.result;
                        ovf_reg <= ovf_reg | alu_rsp.sat;
                        if (i_reg == gdi_pkg::LAST_IDX) begin
                            i_reg     <= '0;
                            state_reg <= S_SC_RD;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_DET;
                        end
                    end
                end
                S_SC_RD: begin
                    state_reg <= S_SC_DIV;
                end
                S_SC_DIV: begin
                    state_reg <= S_SC_DIV_W;
                end
                S_SC_DIV_W: begin
                    if (alu_rsp.done) begin
                        p_reg     <= alu_rsp.result;
                        ovf_reg   <= ovf_reg | alu_rsp.sat;
                        r_reg     <= i_reg;
                        c_reg     <= '0;
                        m_sel_reg <= 1'b0;
                        phase_reg <= PH_SCALE;
                        state_reg <= S_RS_RD;
                    end
                end
                S_BK_PIV: begin
                    state_reg <= S_BK_CHK;
                end
                S_BK_CHK: begin
                    pivot_reg <= work_rd;
                    if (work_rd == '0) begin
                        m_valid_reg         <= 1'b1;
                        m_inverse_value_reg <= '0;
                        m_row_index_reg     <= '0;
                        m_column_index_reg  <= '0;
                        m_determinant_reg   <= det_reg;
                        m_singular_reg      <= 1'b1;
                        m_overflow_reg      <= ovf_reg;
                        m_last_reg          <= 1'b1;
                        state_reg           <= S_OUT_W;
                    end else begin
                        state_reg <= S_BK_RD;
                    end
                end
                S_BK_RD: begin
                    state_reg <= S_BK_DIV;
                end
                S_BK_DIV: begin
                    state_reg <= S_BK_DIV_W;
                end
                S_BK_DIV_W: begin
                    if (alu_rsp.done) begin
                        p_reg     <= alu_rsp.result;
                        ovf_reg   <= ovf_reg | alu_rsp.sat;
                        c_reg     <= '0;
                        m_sel_reg <= 1'b0;
                        phase_reg <= PH_BACK;
                        state_reg <= S_RS_RD;
                    end
                end
                S_RS_RD: begin
                    state_reg <= S_RS_MUL;
                end
                S_RS_MUL: begin
                    state_reg <= S_RS_MUL_W;
                end
                S_RS_MUL_W: begin
                    if (alu_rsp.done) begin
                        t_reg   <= alu_rsp.result;
                        ovf_reg <= ovf_reg | alu_rsp.sat;
                        if (phase_reg == PH_SCALE) begin
                            state_reg <= S_RS_SUB_W;
                        end else begin
                            state_reg <= S_RS_SUB;
                        end
                    end
                end
                S_RS_SUB: begin
                    state_reg <= S_RS_SUB_W;
                end
                S_RS_SUB_W: begin
                    if (alu_rsp.done || phase_reg == PH_SCALE) begin
                        if (phase_reg != PH_SCALE) begin
                            ovf_reg <= ovf_reg | alu_rsp.sat;
                        end
                        if (!m_sel_reg) begin
                            m_sel_reg <= 1'b1;
                            state_reg <= S_RS_RD;
                        end else if (c_reg != gdi_pkg::LAST_IDX) begin
                            m_sel_reg <= 1'b0;
                            c_reg     <= c_reg + 1'b1;
                            state_reg <= S_RS_RD;
                        end else begin
                            m_sel_reg <= 1'b0;
                            case (phase_reg)
                                PH_DOWN: begin
                                    if (r_reg == i_reg + 1'b1) begin
                                        i_reg     <= i_reg + 1'b1;
                                        state_reg <= S_DN_PIV;
                                    end else begin
                                        r_reg     <= r_reg - 1'b1;
                                        state_reg <= S_DN_RD;
                                    end
                                end
                                PH_SCALE: begin
                                    if (i_reg == gdi_pkg::LAST_IDX) begin
                                        r_reg     <= '0;
                                        state_reg <= S_BK_PIV;
                                    end else begin
                                        i_reg     <= i_reg + 1'b1;
                                        state_reg <= S_SC_RD;
                                    end
                                end
                                default: begin
                                    if (r_reg == i_reg - 1'b1) begin
                                        r_reg <= '0;
                                        if (i_reg == gdi_pkg::IDX_ONE) begin
                                            c_reg     <= '0;
                                            state_reg <= S_OUT_RD;
                                        end else begin
                                            i_reg     <= i_reg - 1'b1;
                                            state_reg <= S_BK_PIV;
                                        end
                                    end else begin
                                        r_reg     <= r_reg + 1'b1;
                                        state_reg <= S_BK_PIV;
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_OUT_RD: begin
                    state_reg <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    m_valid_reg         <= 1'b1;
                    m_inverse_value_reg <= inv_rd;
                    m_row_index_reg     <= r_reg;
                    m_column_index_reg  <= c_reg;
                    m_determinant_reg   <= det_reg;
                    m_singular_reg      <= 1'b0;
                    m_overflow_reg      <= ovf_reg;
                    m_last_reg          <= (r_reg == gdi_pkg::LAST_IDX)
                                        && (c_reg == gdi_pkg::LAST_IDX);
                    state_reg           <= S_OUT_W;
                end
                S_OUT_W: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            state_reg <= S_LOAD;
                        end else begin
                            if (c_reg == gdi_pkg::LAST_IDX) begin
                                c_reg <= '0;
                                r_reg <= r_reg + 1'b1;
                            end else begin
                                c_reg <= c_reg + 1'b1;
                            end
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_inverse_value = m_inverse_value_reg;
    assign m_row_index     = m_row_index_reg;
    assign m_column_index  = m_column_index_reg;
    assign m_determinant   = m_determinant_reg;
    assign m_singular      = m_singular_reg;
    assign m_overflow      = m_overflow_reg;
    assign m_last          = m_last_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    a_singular_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_singular) |-> (m_last && m_inverse_value == '0))
        else $error("singular result is not a lone zero result");

    a_alu_single: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_req.start |=> !alu_req.start)
        else $error("shared unit started twice in a row");
`endif

endmodule

>>> tb/gauss_determinant_and_inverse_top_test.sv
// ----------------------------------------------------------------------------
// gauss_determinant_and_inverse_top_test
// Streams 5x5 fixed-point matrices into the inverter under random idling on
// both handshakes and checks every inverse entry, determinant and status flag
// against an in-bench fixed-point Gauss-Jordan model. The first matrix is the
// identity, whose inverse and determinant are typed in directly. It is
// followed by random matrices: well-conditioned, zero-pivot, full-range,
// tiny-valued and huge-valued.
// ----------------------------------------------------------------------------
module gauss_determinant_and_inverse_top_test;

    localparam int RANDOM_MATRICES = 12;
    localparam int CYCLE_LIMIT     = 400000;

    typedef enum int {
        MK_PLAIN,
        MK_ZERO_PIVOT,
        MK_FULL_RANGE,
        MK_TINY,
        MK_HUGE
    } matrix_kind_t;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] det;
        logic        singular;
        logic        overflow;
        logic        last;
    } inverse_entry_t;

    typedef struct {
        logic [31:0] element;
        bit          typed;
    } stimulus_row_t;

    logic        aclk = 0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_element;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_inverse_value;
    logic [2:0]  m_row_index;
    logic [2:0]  m_column_index;
    logic [31:0] m_determinant;
    logic        m_singular;
    logic        m_overflow;
    logic        m_last;

    inverse_entry_t pending_entries[$];
    int             error_count = 0;
    int             cycle_count = 0;
    bit             no_gaps     = 0;

    int work[gdi_pkg::CELLS];
    int inv_rows[gdi_pkg::CELLS];
    int det_acc;
    int fill_count = 0;
    bit clipped;

    gauss_determinant_and_inverse_top dut (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL gauss_determinant_and_inverse_top");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic int clip(longint v);
        if (v > longint'(32'sh7fffffff)) begin
            clipped = 1;
            return 32'sh7fffffff;
        end
        if (v < -longint'(64'sd2147483648)) begin
            clipped = 1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic int qmul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b) + (longint'(1) << (gdi_pkg::FRACTION_BITS - 1));
        return clip(p >>> gdi_pkg::FRACTION_BITS);
    endfunction

    function automatic int qdiv(int a, int b);
        longint n;
        n = longint'(a) * (longint'(1) << gdi_pkg::FRACTION_BITS);
        return clip(n / longint'(b));
    endfunction

    function automatic int qsub(int a, int b);
        return clip(longint'(a) - longint'(b));
    endfunction

    function automatic void row_subtract(int dst, int src, int p);
        int d;
        int s;
        for (int c = 0; c < gdi_pkg::MATRIX_SIZE; c++) begin
            d = dst * gdi_pkg::MATRIX_SIZE + c;
            s = src * gdi_pkg::MATRIX_SIZE + c;
            work[d]     = qsub(work[d], qmul(work[s], p));
            inv_rows[d] = qsub(inv_rows[d], qmul(inv_rows[s], p));
        end
    endfunction

    function automatic int pivot(int i);
        return work[i * gdi_pkg::MATRIX_SIZE + i];
    endfunction

    function automatic bit eliminate();
        int one;
        int p;
        int k;
        one = int'(gdi_pkg::ONE);
        for (int i = 0; i < gdi_pkg::CELLS; i++) inv_rows[i] = 0;
        for (int i = 0; i < gdi_pkg::MATRIX_SIZE; i++)
            inv_rows[i * gdi_pkg::MATRIX_SIZE + i] = one;
        det_acc = 0;
        for (int i = 0; i < gdi_pkg::MATRIX_SIZE; i++) begin
            if (pivot(i) == 0) return 0;
            for (int r = gdi_pkg::MATRIX_SIZE - 1; r > i; r--)
                row_subtract(r, i, qdiv(work[r * gdi_pkg::MATRIX_SIZE + i], pivot(i)));
        end
        det_acc = one;
        for (int i = 0; i < gdi_pkg::MATRIX_SIZE; i++) det_acc = qmul(det_acc, pivot(i));
        for (int i = 0; i < gdi_pkg::MATRIX_SIZE; i++) begin
            p = qdiv(one, pivot(i));
            for (int c = 0; c < gdi_pkg::MATRIX_SIZE; c++) begin
                k = i * gdi_pkg::MATRIX_SIZE + c;
                work[k]     = qmul(work[k], p);
                inv_rows[k] = qmul(inv_rows[k], p);
            end
        end
        for (int i = gdi_pkg::MATRIX_SIZE - 1; i >= 0; i--) begin
            for (int r = 0; r < i; r++) begin
                if (pivot(i) == 0) return 0;
                row_subtract(r, i, qdiv(work[r * gdi_pkg::MATRIX_SIZE + i], pivot(i)));
            end
        end
        return 1;
    endfunction

    // Load one element; on the last one of a matrix, queue its inverse entries.
    function automatic void load_element(logic [31:0] v, bit typed);
        inverse_entry_t e;
        bit ok;
        work[fill_count] = int'($signed(v));
        fill_count++;
        if (fill_count < gdi_pkg::CELLS) return;
        fill_count = 0;
        clipped = 0;
        ok = eliminate();
        if (!ok) begin
            e = '{32'd0, 3'd0, 3'd0, det_acc, 1'b1, clipped, 1'b1};
            pending_entries.push_back(e);
            return;
        end
        for (int r = 0; r < gdi_pkg::MATRIX_SIZE; r++) begin
            for (int c = 0; c < gdi_pkg::MATRIX_SIZE; c++) begin
                if (typed)
                    e = '{(r == c) ? gdi_pkg::ONE : 32'd0, 3'(r), 3'(c), gdi_pkg::ONE,
                          1'b0, 1'b0, 1'b0};
                else
                    e = '{inv_rows[r * gdi_pkg::MATRIX_SIZE + c], 3'(r), 3'(c), det_acc,
                          1'b0, clipped, 1'b0};
                e.last = (r == gdi_pkg::MATRIX_SIZE - 1) && (c == gdi_pkg::MATRIX_SIZE - 1);
                pending_entries.push_back(e);
            end
        end
    endfunction

    task automatic send_element(logic [31:0] v, bit typed);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1;
        s_element = v;
        do @(posedge aclk); while (!s_ready);
        load_element(v, typed);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] small_offdiag();
        return 32'($signed($urandom_range(0, 65536)) - 32768);
    endfunction

    function automatic logic [31:0] pick_element(matrix_kind_t kind, int r, int c,
                                                 int zero_row);
        logic [31:0] mag;
        bit diag;
        diag = (r == c);
        case (kind)
            MK_PLAIN, MK_ZERO_PIVOT: begin
                if (kind == MK_ZERO_PIVOT && diag && r == zero_row) return 32'd0;
                if (!diag) return small_offdiag();
                mag = gdi_pkg::ONE + $urandom_range(0, 3 * gdi_pkg::ONE);
            end
            MK_FULL_RANGE: begin
                case ($urandom_range(0, 7))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    default: return $urandom;
                endcase
            end
            MK_TINY: begin
                if (!diag) return 32'($signed($urandom_range(0, 20)) - 10);
                mag = $urandom_range(1, 300);
            end
            default: begin
                if (!diag) return small_offdiag();
                mag = $urandom_range(100 * gdi_pkg::ONE, 30000 * gdi_pkg::ONE);
            end
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    initial begin
        stimulus_row_t table_rows[$];
        matrix_kind_t  kind;
        int            zero_row;
        int            w;

        aresetn   = 0;
        s_valid   = 0;
        s_element = 0;
        m_ready   = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        for (int r = 0; r < gdi_pkg::MATRIX_SIZE; r++)
            for (int c = 0; c < gdi_pkg::MATRIX_SIZE; c++)
                table_rows.push_back('{(r == c) ? gdi_pkg::ONE : 32'd0, 1'b1});
        foreach (table_rows[i]) send_element(table_rows[i].element, table_rows[i].typed);

        s_valid = 0;
        wait (pending_entries.size() == 0);
        @(negedge aclk);

        for (int m = 0; m < RANDOM_MATRICES; m++) begin
            w        = $urandom_range(0, 4);
            kind     = matrix_kind_t'(w);
            zero_row = $urandom_range(0, gdi_pkg::MATRIX_SIZE - 1);
            no_gaps  = ($urandom_range(0, 3) == 0);
            for (int r = 0; r < gdi_pkg::MATRIX_SIZE; r++)
                for (int c = 0; c < gdi_pkg::MATRIX_SIZE; c++)
                    send_element(pick_element(kind, r, c, zero_row), 1'b0);
        end
        s_valid = 0;

        wait (pending_entries.size() == 0);
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("PASS gauss_determinant_and_inverse_top");
        else
            $display("FAIL gauss_determinant_and_inverse_top");
        $finish;
    end

    initial begin
        inverse_entry_t e;
        int stall;
        stall = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_entries.size() == 0) begin
                    report_mismatch("result with no request pending");
                end else begin
                    e = pending_entries.pop_front();
                    if (m_inverse_value !== e.value)
                        report_mismatch($sformatf("inverse_value %h, want %h",
                                                  m_inverse_value, e.value));
                    if (m_row_index !== e.row)
                        report_mismatch($sformatf("row_index %0d, want %0d",
                                                  m_row_index, e.row));
                    if (m_column_index !== e.col)
                        report_mismatch($sformatf("column_index %0d, want %0d",
                                                  m_column_index, e.col));
                    if (m_determinant !== e.det)
                        report_mismatch($sformatf("determinant %h, want %h",
                                                  m_determinant, e.det));
                    if (m_singular !== e.singular)
                        report_mismatch($sformatf("singular %b, want %b",
                                                  m_singular, e.singular));
                    if (m_overflow !== e.overflow)
                        report_mismatch($sformatf("overflow %b, want %b",
                                                  m_overflow, e.overflow));
                    if (m_last !== e.last)
                        report_mismatch($sformatf("last %b, want %b", m_last, e.last));
                end
                stall = no_gaps ? 0 : $urandom_range(0, 10);
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready = 0;
                stall--;
            end else begin
                m_ready = 1;
            end
        end
    end

endmodule

>>> files.f
hdl/gdi_pkg.sv
hdl/gdi_ram.sv
hdl/gdi_alu.sv
hdl/gauss_determinant_and_inverse_top.sv
tb/gauss_determinant_and_inverse_top_test.sv
